FILE: hdl/timestamp_text_parser_defines.svh
// Assertion helpers shared by the parser modules.
// Each macro expects clk and arst_n in scope and is idle while reset is low.
`ifndef TIMESTAMP_TEXT_PARSER_DEFINES_SVH
`define TIMESTAMP_TEXT_PARSER_DEFINES_SVH

// Check cons in the same cycle whenever ante holds.
`define TSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante holds.
`define TSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/tsp_pkg.sv
package tsp_pkg;

	// one text byte as it moves through the pipeline
	typedef struct packed {
		logic [7:0] text_char;
		logic       last_char;
	} tsp_char_t;

	// one parsed timestamp
	typedef struct packed {
		logic signed [15:0] year;
		logic [7:0]         month;
		logic [7:0]         day;
		logic [7:0]         hours;
		logic [7:0]         minutes;
		logic [7:0]         seconds;
		logic [31:0]        millis;
		logic               fields_valid;
	} tsp_result_t;

	// parse mode codes; the unused code behaves as date then time
	localparam logic [1:0] MODE_DATE = 2'd0;
	localparam logic [1:0] MODE_TIME = 2'd1;
	localparam logic [1:0] MODE_BOTH = 2'd2;

	// field slots: date fields first, then time fields
	localparam logic [3:0] SLOT_YEAR    = 4'd0;
	localparam logic [3:0] SLOT_MONTH   = 4'd1;
	localparam logic [3:0] SLOT_DAY     = 4'd2;
	localparam logic [3:0] SLOT_HOURS   = 4'd3;
	localparam logic [3:0] SLOT_MINUTES = 4'd4;
	localparam logic [3:0] SLOT_SECONDS = 4'd5;
	localparam logic [3:0] SLOT_MILLIS  = 4'd6;
	localparam logic [3:0] SLOT_END     = 4'd7;

	localparam logic [2:0] FIELD_LAST = 3'd7;

	// character codes
	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// range limits
	localparam logic [15:0] YEAR_MAX    = 16'd9999;
	localparam logic [7:0]  MONTH_MAX   = 8'd12;
	localparam logic [7:0]  DAY_MAX     = 8'd31;
	localparam logic [7:0]  HOURS_LIM   = 8'd24;
	localparam logic [7:0]  MINUTES_LIM = 8'd60;
	localparam logic [7:0]  SECONDS_LIM = 8'd60;
	localparam logic [31:0] MILLIS_LIM  = 32'd1000000;

endpackage

FILE: hdl/tsp_char_if.sv
interface tsp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink (input valid, input text_char, input last_char, output ready);
endinterface

FILE: hdl/tsp_result_if.sv
interface tsp_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] year;
	logic [7:0]         month;
	logic [7:0]         day;
	logic [7:0]         hours;
	logic [7:0]         minutes;
	logic [7:0]         seconds;
	logic [31:0]        millis;
	logic               fields_valid;

	modport source (
		output valid, output year, output month, output day, output hours,
		output minutes, output seconds, output millis, output fields_valid,
		input ready
	);
	modport sink (
		input valid, input year, input month, input day, input hours,
		input minutes, input seconds, input millis, input fields_valid,
		output ready
	);
endinterface

FILE: hdl/tsp_char_stage.sv
module tsp_char_stage
	import tsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  tsp_char_t in_item,
	output logic      in_ready,
	input  logic      advance,
	output logic      valid_s1,
	output tsp_char_t item_s1
);

	logic valid_s1_q;

	// take a new item when the stage is empty or its item moves on
	assign in_ready = !valid_s1_q || advance;
	assign valid_s1 = valid_s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (in_ready) begin
			valid_s1_q <= in_valid;
		end
	end

	// hold the payload until the item advances
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: hdl/tsp_field_acc.sv
`include "timestamp_text_parser_defines.svh"

module tsp_field_acc
	import tsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        item_valid,
	input  tsp_char_t   item,
	output logic        res_push,
	output tsp_result_t res
);

	logic [1:0]  mode_q;
	logic [2:0]  field_index_q, field_index_n;
	logic        in_run_q, in_run_n;
	logic        stopped_q, stopped_n;
	logic [15:0] year_q, year_n;
	logic [7:0]  month_q, month_n;
	logic [7:0]  day_q, day_n;
	logic [7:0]  hours_q, hours_n;
	logic [7:0]  minutes_q, minutes_n;
	logic [7:0]  seconds_q, seconds_n;
	logic [31:0] millis_q, millis_n;
	logic [3:0]  slot_first, slot_end, slot;
	logic [3:0]  digit;
	logic        date_ok, time_ok;

	function automatic logic [7:0] mac10_8(input logic [7:0] x, input logic [3:0] d);
		mac10_8 = (x << 3) + (x << 1) + {4'd0, d};
	endfunction

	function automatic logic [15:0] mac10_16(input logic [15:0] x, input logic [3:0] d);
		mac10_16 = (x << 3) + (x << 1) + {12'd0, d};
	endfunction

	function automatic logic [31:0] mac10_32(input logic [31:0] x, input logic [3:0] d);
		mac10_32 = (x << 3) + (x << 1) + {28'd0, d};
	endfunction

	// map the mode to its range of field slots
	always_comb begin
		case (mode_q)
			MODE_DATE: begin
				slot_first = SLOT_YEAR;
				slot_end   = SLOT_HOURS;
			end
			MODE_TIME: begin
				slot_first = SLOT_HOURS;
				slot_end   = SLOT_END;
			end
			default: begin
				slot_first = SLOT_YEAR;
				slot_end   = SLOT_END;
			end
		endcase
	end

	assign slot  = slot_first + {1'b0, field_index_q};
	assign digit = 4'(item.text_char - CHAR_ZERO);

	// advance the parse state by one character
	always_comb begin
		field_index_n = field_index_q;
		in_run_n      = in_run_q;
		stopped_n     = stopped_q;
		year_n        = year_q;
		month_n       = month_q;
		day_n         = day_q;
		hours_n       = hours_q;
		minutes_n     = minutes_q;
		seconds_n     = seconds_q;
		millis_n      = millis_q;
		if (!stopped_q) begin
			if (item.text_char >= CHAR_ZERO && item.text_char <= CHAR_NINE) begin
				if (slot < slot_end) begin
					in_run_n = 1'b1;
					case (slot)
						SLOT_YEAR:    year_n    = mac10_16(year_q, digit);
						SLOT_MONTH:   month_n   = mac10_8(month_q, digit);
						SLOT_DAY:     day_n     = mac10_8(day_q, digit);
						SLOT_HOURS:   hours_n   = mac10_8(hours_q, digit);
						SLOT_MINUTES: minutes_n = mac10_8(minutes_q, digit);
						SLOT_SECONDS: seconds_n = mac10_8(seconds_q, digit);
						SLOT_MILLIS:  millis_n  = mac10_32(millis_q, digit);
						default:      ;
					endcase
				end
			end else begin
				// close a digit run on any separator, including the zero byte
				if (in_run_q && field_index_q != FIELD_LAST) begin
					field_index_n = field_index_q + 3'd1;
				end
				in_run_n = 1'b0;
				if (item.text_char == CHAR_NUL) begin
					stopped_n = 1'b1;
				end
			end
		end
	end

	// range checks on the updated fields
	assign date_ok = (year_n[15] || year_n <= YEAR_MAX) && month_n <= MONTH_MAX
		&& day_n <= DAY_MAX;
	assign time_ok = hours_n < HOURS_LIM && minutes_n < MINUTES_LIM
		&& seconds_n < SECONDS_LIM && millis_n < MILLIS_LIM;

	always_comb begin
		res.year    = year_n;
		res.month   = month_n;
		res.day     = day_n;
		res.hours   = hours_n;
		res.minutes = minutes_n;
		res.seconds = seconds_n;
		res.millis  = millis_n;
		case (mode_q)
			MODE_DATE: res.fields_valid = date_ok;
			MODE_TIME: res.fields_valid = time_ok;
			default:   res.fields_valid = date_ok && time_ok;
		endcase
	end

	assign res_push = item_valid && item.last_char;

	// hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BOTH;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// update the parse state; clear it after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_index_q <= '0;
			in_run_q      <= 1'b0;
			stopped_q     <= 1'b0;
			year_q        <= '0;
			month_q       <= '0;
			day_q         <= '0;
			hours_q       <= '0;
			minutes_q     <= '0;
			seconds_q     <= '0;
			millis_q      <= '0;
		end else if (item_valid) begin
			if (item.last_char) begin
				field_index_q <= '0;
				in_run_q      <= 1'b0;
				stopped_q     <= 1'b0;
				year_q        <= '0;
				month_q       <= '0;
				day_q         <= '0;
				hours_q       <= '0;
				minutes_q     <= '0;
				seconds_q     <= '0;
				millis_q      <= '0;
			end else begin
				field_index_q <= field_index_n;
				in_run_q      <= in_run_n;
				stopped_q     <= stopped_n;
				year_q        <= year_n;
				month_q       <= month_n;
				day_q         <= day_n;
				hours_q       <= hours_n;
				minutes_q     <= minutes_n;
				seconds_q     <= seconds_n;
				millis_q      <= millis_n;
			end
		end
	end

	`TSP_ASSERT_NEXT(a_clear_after_last, item_valid && item.last_char, field_index_q == 3'd0 && !stopped_q && !in_run_q && millis_q == 32'd0, "parse state not cleared after final character")
	`TSP_ASSERT_NOW(a_stopped_no_run, stopped_q, !in_run_q, "digit run open after zero byte")

endmodule

FILE: hdl/tsp_out_buf.sv
`include "timestamp_text_parser_defines.svh"

module tsp_out_buf
	import tsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tsp_result_t push_data,
	output logic        room,
	output logic        out_valid,
	input  logic        out_ready,
	output tsp_result_t out_data
);

	tsp_result_t entry_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign room      = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// track fill level and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`TSP_ASSERT_NOW(a_no_overflow, push, cnt_q != 2'd2, "result pushed into full buffer")
	`TSP_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q != 2'd3, "result buffer count out of range")
	`TSP_ASSERT_NEXT(a_pop_drains, pop && !push && cnt_q == 2'd1, cnt_q == 2'd0, "buffer did not drain")

endmodule

FILE: hdl/timestamp_text_parser.sv
// Timestamp text parser.
// Channel text carries one byte per item (text_char, last_char); channel result
// carries one parsed timestamp (year .. millis, fields_valid) per string, issued
// for the item marked last_char. Each run of decimal digits fills the next field;
// other bytes separate fields, and a zero byte ends parsing for that string.
// cfg_we/cfg_wdata write parse_mode (0 date, 1 time, 2 date then time); write it
// only while no string is in flight.
// Throughput: one byte per cycle while the result buffer has room, set by the combinational
// multiply-by-ten and add on the field accumulators. A byte is registered in the byte
// stage on acceptance and parsed as it leaves that stage; the result of the final byte is
// written into the result buffer, and result shows it from there.
// Results queue in a two-entry buffer; while it is full the byte stage holds and
// text.ready drops, so a stalled receiver loses nothing.
// Reset clears the parse state and both queues and sets parse_mode to 2.

module timestamp_text_parser
	import tsp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	tsp_char_if.sink     text,
	tsp_result_if.source result,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_wdata
);

	tsp_char_t   in_item;
	tsp_char_t   item_s1;
	logic        valid_s1;
	logic        advance;
	logic        room;
	logic        res_push;
	tsp_result_t res;
	tsp_result_t out_data;

	assign in_item.text_char = text.text_char;
	assign in_item.last_char = text.last_char;

	// move the registered byte on when a result slot is free
	assign advance = valid_s1 && room;

	tsp_char_stage u_char_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_item  (in_item),
		.in_ready (text.ready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tsp_field_acc u_field_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (advance),
		.item       (item_s1),
		.res_push   (res_push),
		.res        (res)
	);

	tsp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.room      (room),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (out_data)
	);

	// drive the result channel
	assign result.year         = out_data.year;
	assign result.month        = out_data.month;
	assign result.day          = out_data.day;
	assign result.hours        = out_data.hours;
	assign result.minutes      = out_data.minutes;
	assign result.seconds      = out_data.seconds;
	assign result.millis       = out_data.millis;
	assign result.fields_valid = out_data.fields_valid;

endmodule

FILE: tb/sv/tsp_parse_checker.sv
`timescale 1ns / 100ps

module tsp_parse_checker
	import tsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tsp_char_if        text,
	tsp_result_if      result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	output int         fail_count,
	output int         pending
);

	// shadow copy of the register and the parse state
	logic [1:0]  cur_mode;
	logic [2:0]  fields_done;
	logic        in_number;
	logic        nul_seen;
	logic [15:0] acc_year;
	logic [7:0]  acc_month;
	logic [7:0]  acc_day;
	logic [7:0]  acc_hours;
	logic [7:0]  acc_minutes;
	logic [7:0]  acc_seconds;
	logic [31:0] acc_millis;

	// parsed timestamps still owed by the block, oldest first
	tsp_result_t expected_stamps[$];

	function automatic void restart_string();
		fields_done = '0;
		in_number   = 1'b0;
		nul_seen    = 1'b0;
		acc_year    = '0;
		acc_month   = '0;
		acc_day     = '0;
		acc_hours   = '0;
		acc_minutes = '0;
		acc_seconds = '0;
		acc_millis  = '0;
	endfunction

	// close the current digit run, if any
	function automatic void end_number();
		if (in_number && fields_done < FIELD_LAST) begin
			fields_done = fields_done + 3'd1;
		end
		in_number = 1'b0;
	endfunction

	function automatic void parse_text_byte(logic [7:0] ch, logic is_last);
		logic [3:0]  first_slot;
		logic [3:0]  end_slot;
		logic [3:0]  slot;
		logic [7:0]  digit;
		logic        date_ok;
		logic        time_ok;
		tsp_result_t stamp;

		// field window of the current mode; the spare code runs as date then time
		case (cur_mode)
			MODE_DATE: begin
				first_slot = SLOT_YEAR;
				end_slot   = SLOT_HOURS;
			end
			MODE_TIME: begin
				first_slot = SLOT_HOURS;
				end_slot   = SLOT_END;
			end
			default: begin
				first_slot = SLOT_YEAR;
				end_slot   = SLOT_END;
			end
		endcase

		// advance the parse unless a zero byte already ended it
		if (!nul_seen) begin
			if (ch == CHAR_NUL) begin
				nul_seen = 1'b1;
				end_number();
			end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
				slot  = first_slot + {1'b0, fields_done};
				digit = ch - CHAR_ZERO;
				// drop digits once every field of the mode is filled
				if (slot < end_slot) begin
					case (slot)
						SLOT_YEAR:    acc_year    = acc_year * 16'd10 + {8'd0, digit};
						SLOT_MONTH:   acc_month   = acc_month * 8'd10 + digit;
						SLOT_DAY:     acc_day     = acc_day * 8'd10 + digit;
						SLOT_HOURS:   acc_hours   = acc_hours * 8'd10 + digit;
						SLOT_MINUTES: acc_minutes = acc_minutes * 8'd10 + digit;
						SLOT_SECONDS: acc_seconds = acc_seconds * 8'd10 + digit;
						SLOT_MILLIS:  acc_millis  = acc_millis * 32'd10 + {24'd0, digit};
						default: ;
					endcase
					in_number = 1'b1;
				end
			end else begin
				end_number();
			end
		end

		// form the result on the final byte, then start over
		if (is_last) begin
			date_ok = (acc_year[15] || acc_year <= YEAR_MAX) &&
				acc_month <= MONTH_MAX && acc_day <= DAY_MAX;
			time_ok = acc_hours < HOURS_LIM && acc_minutes < MINUTES_LIM &&
				acc_seconds < SECONDS_LIM && acc_millis < MILLIS_LIM;
			stamp.year    = acc_year;
			stamp.month   = acc_month;
			stamp.day     = acc_day;
			stamp.hours   = acc_hours;
			stamp.minutes = acc_minutes;
			stamp.seconds = acc_seconds;
			stamp.millis  = acc_millis;
			case (cur_mode)
				MODE_DATE: stamp.fields_valid = date_ok;
				MODE_TIME: stamp.fields_valid = time_ok;
				default:   stamp.fields_valid = date_ok && time_ok;
			endcase
			expected_stamps.push_back(stamp);
			restart_string();
		end
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		tsp_result_t want;

		if (!arst_n) begin
			restart_string();
			cur_mode = MODE_BOTH;
			expected_stamps.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// predict from every accepted byte
			if (text.valid && text.ready) begin
				parse_text_byte(text.text_char, text.last_char);
			end
			// compare every accepted result with the oldest prediction
			if (result.valid && result.ready) begin
				if (expected_stamps.size() == 0) begin
					$display("%0t: unexpected result: expected none, got year %0d millis %0d",
						$time, result.year, result.millis);
					fail_count++;
				end else begin
					want = expected_stamps.pop_front();
					check_field("year", want.year, result.year);
					check_field("month", want.month, result.month);
					check_field("day", want.day, result.day);
					check_field("hours", want.hours, result.hours);
					check_field("minutes", want.minutes, result.minutes);
					check_field("seconds", want.seconds, result.seconds);
					check_field("millis", want.millis, result.millis);
					check_field("fields_valid", want.fields_valid, result.fields_valid);
				end
			end
			// apply a register write from the next byte on
			if (cfg_we) begin
				cur_mode = cfg_wdata;
			end
			pending = expected_stamps.size();
		end
	end

endmodule

FILE: tb/sv/tb_timestamp_text_parser.sv
`timescale 1ns / 100ps

module tb_timestamp_text_parser;
	import tsp_pkg::*;

	localparam logic [1:0] MODE_SPARE   = 2'd3;    // undefined code, runs as date then time
	localparam int         ITEM_TARGET  = 750;
	localparam int         PHASES       = 6;
	localparam int         HOLD_CYCLES  = 150;
	localparam int         QUIET_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 8;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;
	int         fail_count;
	int         pending;
	int         items_sent   = 0;
	int         quiet_cycles = 0;
	bit         tx_idle_en   = 1'b1;
	bit         rx_stall_en  = 1'b1;
	bit         rx_hold_req  = 1'b0;
	logic [7:0] text_bytes[$];
	logic [1:0] phase_modes[PHASES] =
		'{MODE_TIME, MODE_DATE, MODE_SPARE, MODE_BOTH, MODE_DATE, MODE_TIME};

	tsp_char_if   text_ch ();
	tsp_result_if result_ch ();

	timestamp_text_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tsp_parse_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.result     (result_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void add_chars(string s);
		foreach (s[i]) text_bytes.push_back(s[i]);
	endfunction

	// one byte between fields: common punctuation or any other non-digit
	function automatic void add_separator();
		logic [7:0] ch;

		case ($urandom_range(0, 7))
			0: ch = "-";
			1: ch = "/";
			2: ch = "T";
			3: ch = " ";
			4: ch = ":";
			5: ch = ".";
			default: begin
				ch = 8'($urandom_range(1, 255));
				if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
					ch = ch ^ 8'h40;
				end
			end
		endcase
		text_bytes.push_back(ch);
	endfunction

	// digits for one field: mostly in range, sometimes just over, sometimes long
	function automatic void add_field(logic [3:0] slot);
		int unsigned in_max;
		int unsigned just_over;
		string       s;

		case (slot)
			SLOT_YEAR:    begin in_max = 32'(YEAR_MAX);  just_over = YEAR_MAX + 1;      end
			SLOT_MONTH:   begin in_max = 32'(MONTH_MAX); just_over = MONTH_MAX + 1;     end
			SLOT_DAY:     begin in_max = 32'(DAY_MAX);   just_over = DAY_MAX + 1;       end
			SLOT_HOURS:   begin in_max = HOURS_LIM - 1;   just_over = 32'(HOURS_LIM);   end
			SLOT_MINUTES: begin in_max = MINUTES_LIM - 1; just_over = 32'(MINUTES_LIM); end
			SLOT_SECONDS: begin in_max = SECONDS_LIM - 1; just_over = 32'(SECONDS_LIM); end
			SLOT_MILLIS:  begin in_max = MILLIS_LIM - 1;  just_over = MILLIS_LIM;       end
			default:      begin in_max = 99;              just_over = 100;              end
		endcase
		case ($urandom_range(0, 7))
			0: s = $sformatf("%0d", just_over);
			1, 2: begin
				s = "";
				repeat ($urandom_range(1, 12)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
			end
			default: s = $sformatf("%0d", $urandom_range(0, in_max));
		endcase
		if ($urandom_range(0, 7) == 0) begin
			s = {"0", s};
		end
		add_chars(s);
	endfunction

	// well-formed string for a mode, with short, long and zero-cut variants
	function automatic void build_timestamp(logic [1:0] mode);
		logic [3:0] first_slot;
		int         nfields;
		int         count;

		first_slot = (mode == MODE_TIME) ? SLOT_HOURS : SLOT_YEAR;
		nfields    = (mode == MODE_DATE) ? 3 : (mode == MODE_TIME) ? 4 : 7;
		case ($urandom_range(0, 7))
			0:       count = $urandom_range(0, nfields - 1);
			1:       count = nfields + $urandom_range(1, 2);
			default: count = nfields;
		endcase
		if ($urandom_range(0, 4) == 0) begin
			add_separator();
		end
		for (int k = 0; k < count; k++) begin
			if (k > 0) begin
				add_separator();
				if ($urandom_range(0, 5) == 0) begin
					add_separator();
				end
			end
			add_field(first_slot + k[3:0]);
		end
		if ($urandom_range(0, 3) == 0 || text_bytes.size() == 0) begin
			add_separator();
		end
		if ($urandom_range(0, 7) == 0) begin
			text_bytes.insert($urandom_range(0, text_bytes.size() - 1), CHAR_NUL);
		end
	endfunction

	// short string of arbitrary bytes
	function automatic void build_noise();
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(0, 9))
				0:       text_bytes.push_back(CHAR_NUL);
				1, 2, 3: text_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
				default: text_bytes.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	// offer one item after a random gap and hold it until accepted
	task automatic send_item(logic [7:0] ch, logic is_last);
		int gap;

		gap = tx_idle_en ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			@(negedge clk);
			text_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		text_ch.valid     <= 1'b1;
		text_ch.text_char <= ch;
		text_ch.last_char <= is_last;
		do @(posedge clk); while (!text_ch.ready);
		items_sent++;
	endtask

	task automatic send_text();
		foreach (text_bytes[i]) send_item(text_bytes[i], i == text_bytes.size() - 1);
		text_bytes.delete();
	endtask

	// drop valid before any wait so no item is taken twice
	task automatic tx_quiet();
		@(negedge clk);
		text_ch.valid <= 1'b0;
	endtask

	task automatic write_parse_mode(logic [1:0] mode);
		tx_quiet();
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result receiver: random stalls, plus one long hold on request
	initial begin
		int gap;

		result_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = rx_stall_en ? $urandom_range(0, 7) : 0;
			end
			if (gap > 0) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid && !rx_hold_req);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) ||
				(result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int strings;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = MODE_BOTH;
		text_ch.valid     = 1'b0;
		text_ch.text_char = CHAR_NUL;
		text_ch.last_char = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// lone high non-digit byte: empty string, every field zero
		text_bytes.push_back(8'hff);
		send_text();
		// year over its limit, month at the top of its width
		add_chars("10000.255");
		send_text();
		// zero byte ends parsing, the digit after it is ignored
		add_chars("7");
		text_bytes.push_back(CHAR_NUL);
		add_chars("8");
		send_text();
		// year wraps past 16 bits into the negative range
		add_chars("99999");
		send_text();
		// digit run closed by the last byte itself
		add_chars("1");
		send_text();
		// digits beyond the date fields are dropped
		write_parse_mode(MODE_DATE);
		add_chars("1.2.3.4");
		send_text();

		for (int p = 0; p < PHASES; p++) begin
			write_parse_mode(phase_modes[p]);
			tx_idle_en  = (p % 3) != 1;
			rx_stall_en = (p % 3) != 2;
			if (p == 2) begin
				// hold the receiver off and keep offering items until the input stalls
				rx_hold_req = 1'b1;
				tx_idle_en  = 1'b0;
				repeat (24) begin
					add_chars("5");
					send_text();
				end
				tx_idle_en = 1'b1;
			end
			strings = 0;
			while (items_sent < ITEM_TARGET * (p + 1) / PHASES) begin
				if ($urandom_range(0, 9) < 7) begin
					build_timestamp(phase_modes[p]);
				end else begin
					build_noise();
				end
				send_text();
				strings++;
				if (p == 4 && strings == 8) begin
					// pause until every outstanding result is back
					tx_quiet();
					wait (pending == 0);
				end
			end
		end

		// drain the last results, then allow for the pipeline
		tx_quiet();
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/tsp_pkg.sv
hdl/tsp_char_if.sv
hdl/tsp_result_if.sv
hdl/tsp_char_stage.sv
hdl/tsp_field_acc.sv
hdl/tsp_out_buf.sv
hdl/timestamp_text_parser.sv
tb/sv/tsp_parse_checker.sv
tb/sv/tb_timestamp_text_parser.sv
